// File: src/isrt_pkg.sv
// shared types and constants for the insertion sorter
`default_nettype none

package isrt_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/insertion_sorter_top.sv
// insertion sorter top level: control and a chain of sorting cells
//
// Input channel (in_valid/in_ready, value, last) takes one signed 32-bit
// value per transaction. Each value is inserted into an ascending chain of
// CAPACITY cells in the cycle it is accepted, so a run loads at one value
// per cycle. Equal values keep their arrival order. Values that arrive
// while the chain is full are dropped and flag the whole run as overflowed.
// Once the transaction marked last is accepted, in_ready drops and the run
// is shifted out of cell 0, one value per cycle, through an output register
// (out_valid/out_ready, sorted_value, last_res, overflow); last_res marks
// the final value. The first result enters the output register after the
// state register has entered DRAIN; in_ready rises again once the run drains.
// When the receiver stalls, the drain simply pauses with the chain intact.
// Reset empties the chain and clears the overflow flag; cell contents are
// not cleared since unfilled cells are never read.
`default_nettype none

module insertion_sorter_top #(
    parameter int CAPACITY = isrt_pkg::CAPACITY_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire isrt_pkg::data_t value,
    input  wire logic         last,
    output logic              out_valid,
    input  wire logic         out_ready,
    output isrt_pkg::data_t   sorted_value,
    output logic              last_res,
    output logic              overflow
);
    import isrt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        IDLE,
        DRAIN
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              dropped_reg;
    logic              out_valid_reg;
    data_t             sorted_reg;
    logic              last_res_reg;
    logic              overflow_reg;

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              full;

    data_t             cell_val [CAPACITY];
    logic              cell_gt  [CAPACITY];

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid & in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));

    assign ctrl.insert = accept & ~full;
    assign ctrl.drain  = (state_reg == DRAIN) & (~out_valid_reg | out_ready);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        data_t left_v;
        logic  left_g;
        data_t right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_val[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_v = '0;
        end
        else
        begin : g_inner
            assign right_v = cell_val[i+1];
        end

        isrt_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .ins_value    (value),
            .empty        (CNT_W'(i) >= count_reg),
            .left_value   (left_v),
            .left_greater (left_g),
            .right_value  (right_v),
            .cell_value   (cell_val[i]),
            .greater      (cell_gt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sorted_reg    <= '0;
            last_res_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.drain)
            begin
                out_valid_reg <= 1'b1;
                sorted_reg    <= cell_val[0];
                last_res_reg  <= (count_reg == CNT_W'(1));
                overflow_reg  <= dropped_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= DRAIN;
                        end
                    end
                end
                DRAIN:
                begin
                    if (ctrl.drain)
                    begin
                        count_reg <= count_reg - 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            state_reg   <= IDLE;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_reg;
    assign last_res     = last_res_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

// File: src/isrt_cell.sv
// one cell of the sorting chain: holds a single value of the run
`default_nettype none

module isrt_cell (
    input  wire logic                clk,
    input  wire isrt_pkg::cell_ctrl_t ctrl,
    input  wire isrt_pkg::data_t     ins_value,
    input  wire logic                empty,
    input  wire isrt_pkg::data_t     left_value,
    input  wire logic                left_greater,
    input  wire isrt_pkg::data_t     right_value,
    output isrt_pkg::data_t          cell_value,
    output logic                     greater
);
    import isrt_pkg::*;

    data_t val_reg;
    data_t val_next;

    // an unfilled cell behaves as if it held plus infinity
    assign greater    = empty | (val_reg > ins_value);
    assign cell_value = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert && greater)
        begin
            val_next = left_greater ? left_value : ins_value;
        end
        else if (ctrl.drain)
        begin
            val_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire
